// ===== rtl/okl_pkg.sv =====
// okl_pkg: widths, codes and shared types of the ordered keyed list table
// used by okl_cell, okl_chain and ordered_keyed_list_table; no dependencies
package okl_pkg;

   localparam int CAPACITY = 32;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int FUNC_W   = 3;
   localparam int STAT_W   = 3;
   localparam int KEY_W    = 32;
   localparam int PAY_W    = 32;

   localparam logic [FUNC_W-1:0] FUNC_ADD       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE    = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH    = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PRINT_FWD = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PRINT_REV = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STATUS_DUP      = 3'd1;
   localparam logic [STAT_W-1:0] STATUS_NOTFOUND = 3'd2;
   localparam logic [STAT_W-1:0] STATUS_EMPTY    = 3'd3;
   localparam logic [STAT_W-1:0] STATUS_FULL     = 3'd4;

   typedef struct packed {
      logic                    valid;
      logic signed [KEY_W-1:0] key;
      logic [PAY_W-1:0]        payload;
   } entry_type;

   typedef struct packed {
      logic rotate;
      logic compact;
   } cell_ctrl_type;

   typedef struct packed {
      logic rotate;
      logic reverse;
      logic drop;
      logic compact;
      logic write;
   } chain_ctrl_type;

endpackage

// ===== rtl/okl_cell.sv =====
// okl_cell: one entry of the ring, loads from its ring source, closes a hole
// from its upper neighbour or takes a new entry; uses okl_pkg
module okl_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  okl_pkg::cell_ctrl_type ctrl,
   input  okl_pkg::entry_type     rot_src,
   input  okl_pkg::entry_type     up,
   input  logic                   down_valid,
   input  logic                   wr_sel,
   input  okl_pkg::entry_type     new_entry,
   output okl_pkg::entry_type     cur
);
   import okl_pkg::*;

   entry_type cur_ff;
   entry_type cur_in;

   always_comb begin
      cur_in = cur_ff;
      priority if (wr_sel) begin
         cur_in = new_entry;
      end else if (ctrl.rotate) begin
         cur_in = rot_src;
      end else if (ctrl.compact) begin
         priority if (!cur_ff.valid && up.valid) begin
            cur_in = up;
         end else if (cur_ff.valid && !down_valid) begin
            cur_in.valid = 1'b0;
         end else begin
            cur_in = cur_ff;
         end
      end else begin
         cur_in = cur_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff.valid <= 1'b0;
      end else begin
         cur_ff.valid <= cur_in.valid;
      end
      cur_ff.key     <= cur_in.key;
      cur_ff.payload <= cur_in.payload;
   end

   assign cur = cur_ff;

endmodule

// ===== rtl/okl_chain.sv =====
// okl_chain: ring of okl_cell entries in list order with the head at cell 0
// uses okl_pkg and okl_cell
module okl_chain (
   input  logic                         clock,
   input  logic                         reset,
   input  okl_pkg::chain_ctrl_type      ctrl,
   input  logic [okl_pkg::CNT_W-1:0]    wr_index,
   input  okl_pkg::entry_type           new_entry,
   output okl_pkg::entry_type           head,
   output logic [okl_pkg::CAPACITY-1:0] occ
);
   import okl_pkg::*;

   entry_type     cells [CAPACITY];
   cell_ctrl_type cell_ctrl;

   assign cell_ctrl = '{rotate: ctrl.rotate, compact: ctrl.compact};

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam int NXT = (i + 1) % CAPACITY;
      localparam int PRV = (i + CAPACITY - 1) % CAPACITY;

      entry_type rot_src;
      entry_type up;
      logic      down_valid;
      logic      wr_sel;

      always_comb begin
         rot_src = ctrl.reverse ? cells[PRV] : cells[NXT];
         if (i == CAPACITY - 1 && !ctrl.reverse && ctrl.drop) begin
            rot_src.valid = 1'b0;
         end
         up = cells[NXT];
         if (i == CAPACITY - 1) begin
            up.valid = 1'b0;
         end
         down_valid = (i == 0) ? 1'b1 : cells[PRV].valid;
         wr_sel     = ctrl.write && (wr_index == CNT_W'(i));
      end

      okl_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .rot_src    (rot_src),
         .up         (up),
         .down_valid (down_valid),
         .wr_sel     (wr_sel),
         .new_entry  (new_entry),
         .cur        (cells[i])
      );

      assign occ[i] = cells[i].valid;
   end

   assign head = cells[0];

endmodule

// ===== rtl/ordered_keyed_list_table.sv =====
// ordered_keyed_list_table: insertion-ordered keyed table on a ring of cells
// uses okl_pkg and okl_chain
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  req_func, req_key, req_payload
//   rsp      out        rsp_valid/rsp_stall  rsp_status, rsp_key_out,
//                                            rsp_payload_out, rsp_last
//
// add and search take one full turn of the ring past the comparator at
// cell 0, then the result word. remove takes the turn, the result, then,
// on a hit, hole closing along the chain. prints take one turn of the
// ring; a stalled rsp halts the ring during a print and holds the result.
// reset clears every cell's valid bit at once.
module ordered_keyed_list_table (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [okl_pkg::FUNC_W-1:0]       req_func,
   input  logic signed [okl_pkg::KEY_W-1:0] req_key,
   input  logic [okl_pkg::PAY_W-1:0]        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [okl_pkg::STAT_W-1:0]       rsp_status,
   output logic signed [okl_pkg::KEY_W-1:0] rsp_key_out,
   output logic [okl_pkg::PAY_W-1:0]        rsp_payload_out,
   output logic                             rsp_last
);
   import okl_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESULT, S_COMPACT} state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [FUNC_W-1:0]       op_ff, op_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [PAY_W-1:0]        pay_ff, pay_in;
   logic                    hit_ff, hit_in;
   logic signed [KEY_W-1:0] hit_key_ff, hit_key_in;
   logic [PAY_W-1:0]        hit_pay_ff, hit_pay_in;
   logic [STAT_W-1:0]       res_status_ff, res_status_in;
   logic signed [KEY_W-1:0] res_key_ff, res_key_in;
   logic [PAY_W-1:0]        res_pay_ff, res_pay_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]       rsp_status_ff, rsp_status_in;
   logic signed [KEY_W-1:0] rsp_key_ff, rsp_key_in;
   logic [PAY_W-1:0]        rsp_pay_ff, rsp_pay_in;
   logic                    rsp_last_ff, rsp_last_in;

   chain_ctrl_type          chain_ctrl;
   entry_type               head;
   entry_type               new_entry;
   logic [CAPACITY-1:0]     occ;

   logic is_print, is_rev, at_end, match, emit_now, can_load, step, last_now, add_ok;

   okl_chain u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (chain_ctrl),
      .wr_index  (count_ff),
      .new_entry (new_entry),
      .head      (head),
      .occ       (occ)
   );

   always_comb begin
      is_print = (op_ff == FUNC_PRINT_FWD) || (op_ff == FUNC_PRINT_REV);
      is_rev   = (op_ff == FUNC_PRINT_REV);
      at_end   = (k_ff == CNT_W'(CAPACITY));
      match    = head.valid && (head.key == key_ff);
      can_load = !rsp_valid_ff || !rsp_stall;
      emit_now = (state_ff == S_SCAN) && is_print && head.valid &&
                 (is_rev ? (k_ff != '0) : !at_end);
      step     = (state_ff == S_SCAN) && !at_end && (!emit_now || can_load);
      last_now = is_rev ? at_end : (k_ff == count_ff - CNT_W'(1));
      add_ok   = (op_ff == FUNC_ADD) && !hit_ff && !occ[CAPACITY-1];

      new_entry = '{valid: 1'b1, key: key_ff, payload: pay_ff};

      chain_ctrl.rotate  = step;
      chain_ctrl.reverse = is_rev;
      chain_ctrl.drop    = (op_ff == FUNC_REMOVE) && match;
      chain_ctrl.compact = (state_ff == S_COMPACT);
      chain_ctrl.write   = (state_ff == S_SCAN) && at_end && add_ok;
   end

   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      pay_in        = pay_ff;
      hit_in        = hit_ff;
      hit_key_in    = hit_key_ff;
      hit_pay_in    = hit_pay_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_pay_in    = res_pay_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_last_in   = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in  = req_func;
               key_in = req_key;
               pay_in = req_payload;
               k_in   = '0;
               hit_in = 1'b0;
               unique case (req_func)
                  FUNC_ADD, FUNC_REMOVE, FUNC_SEARCH: begin
                     state_in = S_SCAN;
                  end
                  FUNC_PRINT_FWD, FUNC_PRINT_REV: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                        res_key_in    = '0;
                        res_pay_in    = '0;
                        state_in      = S_RESULT;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (step) begin
               k_in = k_ff + CNT_W'(1);
               if (!is_print && match) begin
                  hit_in     = 1'b1;
                  hit_key_in = head.key;
                  hit_pay_in = head.payload;
               end
            end
            if (emit_now && can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_key_in    = head.key;
               rsp_pay_in    = head.payload;
               rsp_last_in   = last_now;
            end
            if (at_end) begin
               if (is_print) begin
                  if (!emit_now || can_load) begin
                     state_in = S_IDLE;
                  end
               end else begin
                  state_in = S_RESULT;
                  priority if (op_ff == FUNC_ADD) begin
                     priority if (hit_ff) begin
                        res_status_in = STATUS_DUP;
                        res_key_in    = '0;
                        res_pay_in    = '0;
                     end else if (occ[CAPACITY-1]) begin
                        res_status_in = STATUS_FULL;
                        res_key_in    = '0;
                        res_pay_in    = '0;
                     end else begin
                        res_status_in = STATUS_OK;
                        res_key_in    = key_ff;
                        res_pay_in    = pay_ff;
                        count_in      = count_ff + CNT_W'(1);
                     end
                  end else if (hit_ff) begin
                     res_status_in = STATUS_OK;
                     res_key_in    = hit_key_ff;
                     res_pay_in    = hit_pay_ff;
                     if (op_ff == FUNC_REMOVE) begin
                        count_in = count_ff - CNT_W'(1);
                     end
                  end else begin
                     res_status_in = STATUS_NOTFOUND;
                     res_key_in    = '0;
                     res_pay_in    = '0;
                  end
               end
            end
         end
         S_RESULT: begin
            if (can_load) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_key_ff;
               rsp_pay_in    = res_pay_ff;
               rsp_last_in   = 1'b1;
               k_in          = '0;
               state_in      = ((op_ff == FUNC_REMOVE) && hit_ff) ? S_COMPACT : S_IDLE;
            end
         end
         S_COMPACT: begin
            k_in = k_ff + CNT_W'(1);
            if (k_ff == CNT_W'(CAPACITY - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         k_ff         <= '0;
         count_ff     <= '0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         count_ff     <= count_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      pay_ff        <= pay_in;
      hit_key_ff    <= hit_key_in;
      hit_pay_ff    <= hit_pay_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_pay_ff    <= res_pay_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_key_out     = rsp_key_ff;
   assign rsp_payload_out = rsp_pay_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTH
   a_idle_count : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ($countones(occ) == int'(count_ff)))
      else $error("cell occupancy differs from entry count");

   a_idle_packed : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> ((occ & (occ + CAPACITY'(1))) == '0))
      else $error("hole left in the chain while idle");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_SCAN || $past(state_ff) == S_RESULT))
      else $error("result word raised outside scan or result");
`endif

endmodule
